[hw/rtl/mowm_pkg.sv]
// Shared constants and controller/datapath handshake types for min_of_window_maxima.
package mowm_pkg;

	localparam int MAX_WINDOW = 64;
	localparam int VALUE_BITS = 32;
	localparam int LEN_BITS   = 7;
	localparam int PTR_BITS   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_BITS   = $clog2(MAX_WINDOW + 1);

	typedef struct packed {
		logic accept;  // take the input transaction
		logic rd;      // issue one window read
		logic finish;  // fold into running minimum, emit on last
	} mowm_cmd_t;

	typedef struct packed {
		logic cnt_zero;  // no window reads left
		logic last;      // current item closes the stream
		logic out_free;  // output register can be loaded
	} mowm_sts_t;

endpackage

[hw/rtl/mowm_ctrl.sv]
// Sequencer for min_of_window_maxima: accept, scan window, finish.
module mowm_ctrl
	import mowm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  mowm_sts_t sts,
	output mowm_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t state_q;

	always_comb begin
		in_ready   = (state_q == S_IDLE);
		cmd.accept = in_ready && in_valid;
		cmd.rd     = (state_q == S_SCAN) && !sts.cnt_zero;
		cmd.finish = (state_q == S_FINISH) && (!sts.last || sts.out_free);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (sts.cnt_zero) state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (!sts.last || sts.out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[hw/rtl/mowm_dp.sv]
// Datapath for min_of_window_maxima: window ring memory, max scan, running minimum.
module mowm_dp
	import mowm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [LEN_BITS-1:0]   cfg_wr_data,
	input  logic [VALUE_BITS-1:0] sample_value,
	input  logic                  last_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [VALUE_BITS-1:0] min_of_maxima,
	output logic                  short_stream,
	input  mowm_cmd_t             cmd,
	output mowm_sts_t             sts
);

	logic [VALUE_BITS-1:0] mem [MAX_WINDOW];

	logic [LEN_BITS-1:0]   len_q;
	logic [PTR_BITS-1:0]   wr_pos_q;
	logic [PTR_BITS-1:0]   rd_addr_q;
	logic [CNT_BITS-1:0]   items_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  last_q;
	logic                  full_q;
	logic                  rd_vld_q;
	logic [VALUE_BITS-1:0] rd_data_q;
	logic [VALUE_BITS-1:0] run_max_q;
	logic [VALUE_BITS-1:0] best_q;
	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] out_value_q;
	logic                  out_short_q;

	logic [CNT_BITS-1:0]   len_eff;
	logic [CNT_BITS-1:0]   items_nxt;
	logic                  full_nxt;
	logic [CNT_BITS-1:0]   count_nxt;
	logic [VALUE_BITS-1:0] best_new;

	always_comb begin
		if (len_q == '0)
			len_eff = CNT_BITS'(1);
		else if (int'(len_q) > MAX_WINDOW)
			len_eff = CNT_BITS'(MAX_WINDOW);
		else
			len_eff = CNT_BITS'(len_q);

		if (int'(items_q) < MAX_WINDOW)
			items_nxt = items_q + CNT_BITS'(1);
		else
			items_nxt = items_q;

		full_nxt = (items_nxt >= len_eff);
		if (full_nxt)
			count_nxt = len_eff;
		else if (last_item)
			count_nxt = items_nxt;
		else
			count_nxt = '0;

		best_new = (full_q && (run_max_q < best_q)) ? run_max_q : best_q;
	end

	always_comb begin
		sts.cnt_zero = (cnt_q == '0);
		sts.last     = last_q;
		sts.out_free = !out_valid_q || out_ready;
	end

	assign out_valid     = out_valid_q;
	assign min_of_maxima = out_value_q;
	assign short_stream  = out_short_q;

	// window memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.accept) mem[wr_pos_q] <= sample_value;
		if (cmd.rd) rd_data_q <= mem[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= LEN_BITS'(1);
			wr_pos_q    <= '0;
			rd_addr_q   <= '0;
			items_q     <= '0;
			cnt_q       <= '0;
			last_q      <= 1'b0;
			full_q      <= 1'b0;
			rd_vld_q    <= 1'b0;
			run_max_q   <= '0;
			best_q      <= '1;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_short_q <= 1'b0;
		end else begin
			if (cfg_wr_en) len_q <= cfg_wr_data;

			rd_vld_q <= cmd.rd;

			if (cmd.accept) begin
				wr_pos_q  <= (int'(wr_pos_q) == MAX_WINDOW - 1) ? '0
				             : wr_pos_q + PTR_BITS'(1);
				rd_addr_q <= wr_pos_q;
				items_q   <= items_nxt;
				cnt_q     <= count_nxt;
				last_q    <= last_item;
				full_q    <= full_nxt;
				run_max_q <= '0;
			end else if (rd_vld_q && (rd_data_q > run_max_q)) begin
				run_max_q <= rd_data_q;
			end

			// walk backward from the newest entry
			if (cmd.rd) begin
				rd_addr_q <= (rd_addr_q == '0) ? PTR_BITS'(MAX_WINDOW - 1)
				             : rd_addr_q - PTR_BITS'(1);
				cnt_q     <= cnt_q - CNT_BITS'(1);
			end

			if (cmd.finish) begin
				if (last_q) begin
					out_value_q <= full_q ? best_new : run_max_q;
					out_short_q <= !full_q;
					best_q      <= '1;
					items_q     <= '0;
					wr_pos_q    <= '0;
				end else begin
					best_q <= best_new;
				end
			end

			if (cmd.finish && last_q)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

[hw/rtl/min_of_window_maxima.sv]
// Top level of min_of_window_maxima: sliding-window maximum with running minimum.
//
//  channel   | handshake                | payload
//  ----------+--------------------------+-------------------------------------
//  in        | in_valid / in_ready      | sample_value[31:0], last_item
//  out       | out_valid / out_ready    | min_of_maxima[31:0], short_stream
//  cfg       | cfg_wr_en (no wait)      | cfg_wr_data[6:0] -> window_length
//
// After acceptance, in_ready stays low through the scan and finish states.
// The scan reads N window entries, where N is the effective window length
// once a full window is present, the items seen so far on a short last item,
// otherwise zero. The scan pace is set by the single read port of the
// 64-entry window memory, one entry per cycle.
// A last item also waits in its final cycle while the previous result is
// still held and out_ready is low; the result register otherwise lets the
// next transaction in while a result waits.
// Reset: window_length = 1, stream state cleared, no result pending. The
// window memory is not cleared; only entries written in the current stream
// are read.
module min_of_window_maxima
	import mowm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [LEN_BITS-1:0]   cfg_wr_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [VALUE_BITS-1:0] sample_value,
	input  logic                  last_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [VALUE_BITS-1:0] min_of_maxima,
	output logic                  short_stream
);

	mowm_cmd_t cmd;  // controller -> datapath
	mowm_sts_t sts;  // datapath -> controller

	// sequencer: accept, scan (one memory read per cycle), finish
	mowm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// window ring, max accumulator, running minimum, result register
	mowm_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.sample_value  (sample_value),
		.last_item     (last_item),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.min_of_maxima (min_of_maxima),
		.short_stream  (short_stream),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule

[hw/rtl/mowm_chk.sv]
// Port-level checker for min_of_window_maxima and its bind.
module mowm_chk
	import mowm_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_wr_en,
	input logic [LEN_BITS-1:0]   cfg_wr_data,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic [VALUE_BITS-1:0] sample_value,
	input logic                  last_item,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [VALUE_BITS-1:0] min_of_maxima,
	input logic                  short_stream
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(min_of_maxima) && $stable(short_stream))
		else $error("result changed while stalled");

	// in_ready drops right after every accepted transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after a transaction");

	// a result is only produced from the finishing cycle, never from idle
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while idle");

endmodule

bind min_of_window_maxima mowm_chk u_mowm_chk (.*);

[dv/mowm_scoreboard_pkg.sv]
// Result predictor and in-order checker for the min_of_window_maxima testbench.
package mowm_scoreboard_pkg;
	import mowm_pkg::*;

	typedef struct packed {
		logic [VALUE_BITS-1:0] minimum;
		logic                  short_flag;
	} mowm_result_t;

	class min_of_maxima_scoreboard;
		logic [VALUE_BITS-1:0] ring [MAX_WINDOW];
		int unsigned           wr_pos;
		int unsigned           stream_count;
		logic [VALUE_BITS-1:0] running_min;
		logic [LEN_BITS-1:0]   window_length;
		mowm_result_t          expected_minima [$];
		int unsigned           fail_count;

		function new();
			foreach (ring[i]) ring[i] = '0;
			window_length = 1;
			fail_count = 0;
			clear_stream();
		endfunction

		function void clear_stream();
			wr_pos = 0;
			stream_count = 0;
			running_min = '1;
		endfunction

		function void set_window_length(logic [LEN_BITS-1:0] len);
			window_length = len;
		endfunction

		// zero acts as 1, oversize saturates
		function int unsigned effective_window();
			if (window_length == 0)
				return 1;
			if (window_length > MAX_WINDOW)
				return MAX_WINDOW;
			return window_length;
		endfunction

		function logic [VALUE_BITS-1:0] recent_max(int unsigned count);
			logic [VALUE_BITS-1:0] best;
			int unsigned           idx;
			best = '0;
			for (int unsigned i = 0; i < count && i < MAX_WINDOW; i++) begin
				idx = (wr_pos + MAX_WINDOW - 1 - i) % MAX_WINDOW;
				if (ring[idx] > best)
					best = ring[idx];
			end
			return best;
		endfunction

		function void note_sample(logic [VALUE_BITS-1:0] value, logic is_last);
			int unsigned           len;
			logic [VALUE_BITS-1:0] win_max;
			mowm_result_t          res;
			len = effective_window();
			ring[wr_pos] = value;
			wr_pos = (wr_pos + 1) % MAX_WINDOW;
			if (stream_count < MAX_WINDOW)
				stream_count++;
			if (stream_count >= len) begin
				win_max = recent_max(len);
				if (win_max < running_min)
					running_min = win_max;
			end
			if (!is_last)
				return;
			if (stream_count < len) begin
				res.minimum = recent_max(stream_count);
				res.short_flag = 1'b1;
			end else begin
				res.minimum = running_min;
				res.short_flag = 1'b0;
			end
			expected_minima = {expected_minima, res};
			clear_stream();
		endfunction

		function void flag_error(string msg);
			fail_count++;
			if (fail_count <= 10)
				$display("ERROR: %s", msg);
		endfunction

		function void check_result(logic [VALUE_BITS-1:0] minimum, logic short_flag);
			mowm_result_t want;
			if (expected_minima.size() == 0) begin
				flag_error($sformatf("unexpected result min_of_maxima=%h short_stream=%b",
					minimum, short_flag));
				return;
			end
			want = expected_minima.pop_front();
			if (want.minimum !== minimum)
				flag_error($sformatf("min_of_maxima expected %h got %h", want.minimum, minimum));
			if (want.short_flag !== short_flag)
				flag_error($sformatf("short_stream expected %b got %b",
					want.short_flag, short_flag));
		endfunction

		function int unsigned pending();
			return expected_minima.size();
		endfunction
	endclass

endpackage

[dv/min_of_window_maxima_test.sv]
// Self-checking testbench for min_of_window_maxima.
module min_of_window_maxima_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mowm_pkg::*;
	import mowm_scoreboard_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int RESET_CYCLES = 6;
	// worst scan reads MAX_WINDOW entries plus overhead; leave margin
	localparam int DRAIN_CYCLES = MAX_WINDOW + 16;
	// longest legal quiet stretch is a drain pause or a long random stall
	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_ITEMS = 850;
	localparam int SUB_PHASES   = 9;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_wr_en    = 1'b0;
	logic [LEN_BITS-1:0]   cfg_wr_data  = '0;
	logic                  in_valid     = 1'b0;
	logic                  in_ready;
	logic [VALUE_BITS-1:0] sample_value = '0;
	logic                  last_item    = 1'b0;
	logic                  out_valid;
	logic                  out_ready    = 1'b0;
	logic [VALUE_BITS-1:0] min_of_maxima;
	logic                  short_stream;

	min_of_maxima_scoreboard sb;
	int unsigned             send_idle_pct = 0;
	int unsigned             recv_idle_pct = 0;
	int unsigned             quiet_cycles  = 0;

	min_of_window_maxima dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample_value  (sample_value),
		.last_item     (last_item),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.min_of_maxima (min_of_maxima),
		.short_stream  (short_stream)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Receiver: random backpressure, one decision per cycle.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Output monitor plus watchdog. Everything is read right after the edge,
	// before any nonblocking update, so it reflects what the DUT saw.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(min_of_maxima, short_stream);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= IDLE_LIMIT) begin
				$display("min_of_window_maxima verification failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Present one sample and hold it until the DUT takes it. Valid is left
	// high on return so a back-to-back transaction needs no toggle; each
	// idle cycle drops it with a single assignment.
	task automatic send_item(input logic [VALUE_BITS-1:0] value, input logic is_last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		sample_value <= value;
		last_item    <= is_last;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_sample(value, is_last);
	endtask

	// Bring the block to idle: no input offered, every result out, and a pause
	// long enough for a full-window scan on a non-last item to finish.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(input logic [LEN_BITS-1:0] len);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= len;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_window_length(len);
	endtask

	// Mix of magnitudes so ties, zeros and all-ones show up often.
	function automatic logic [VALUE_BITS-1:0] pick_sample();
		case ($urandom_range(7))
			0, 1, 2: return $urandom();
			3, 4:    return $urandom_range(15);
			5:       return $urandom_range(1) ? '1 : '0;
			default: return $urandom() >> $urandom_range(31);
		endcase
	endfunction

	// Window setting per random sub-phase; covers zero, 1, MAX_WINDOW and
	// the saturating range above it.
	function automatic logic [LEN_BITS-1:0] pick_window(input int unsigned slot);
		case (slot)
			0:       return LEN_BITS'(1);
			1:       return LEN_BITS'(4);
			2:       return LEN_BITS'(MAX_WINDOW);
			3:       return LEN_BITS'(0);
			4:       return LEN_BITS'(2);
			5:       return '1;
			6:       return LEN_BITS'($urandom_range(16, 1));
			7:       return LEN_BITS'($urandom_range(126, MAX_WINDOW + 1));
			default: return LEN_BITS'($urandom_range(127, 0));
		endcase
	endfunction

	// Whole streams until the budget is used: some tiny, some shorter than
	// a window, most a few items past one full window. The final stream is
	// trimmed so the budget is met exactly.
	task automatic run_streams(input int unsigned budget);
		int unsigned sent;
		int unsigned len;
		int unsigned eff;
		int unsigned kind;
		sent = 0;
		while (sent < budget) begin
			eff = sb.effective_window();
			kind = $urandom_range(99);
			if (kind < 15)
				len = $urandom_range(3, 1);
			else if (kind < 35 && eff > 1)
				len = $urandom_range(eff - 1, 1);
			else
				len = eff + $urandom_range(20, 0);
			if (len > budget - sent)
				len = budget - sent;
			for (int unsigned k = 1; k <= len; k++)
				send_item(pick_sample(), k == len);
			sent += len;
		end
	endtask

	initial begin
		sb = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero window acts as 1; single-item stream of all ones, then a three-item stream.
		write_window(0);
		send_item('1, 1'b1);
		send_item(32'd5, 1'b0);
		send_item(32'd0, 1'b0);
		send_item(32'd7, 1'b1);
		settle();

		// Window 3: short stream, then a full one with an all-ones peak.
		write_window(3);
		send_item(32'd9, 1'b0);
		send_item(32'd2, 1'b1);
		send_item(32'd1, 1'b0);
		send_item(32'd8, 1'b0);
		send_item(32'd3, 1'b0);
		send_item('1, 1'b0);
		send_item(32'd2, 1'b0);
		send_item(32'd4, 1'b1);
		settle();

		// Window length changed in the middle of a stream.
		write_window(2);
		send_item(32'd4, 1'b0);
		send_item(32'd1, 1'b0);
		send_item(32'd6, 1'b0);
		settle();
		write_window(5);
		send_item(32'd3, 1'b0);
		send_item(32'd2, 1'b1);
		settle();

		// Oversize window saturates; short streams of zeros and mixed extremes.
		write_window('1);
		send_item(32'd0, 1'b0);
		send_item(32'd0, 1'b1);
		send_item('1, 1'b0);
		send_item(32'd0, 1'b1);
		settle();

		// Random: three idle profiles, three window settings each.
		for (int unsigned mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle_pct = 12;
					recv_idle_pct = 48;
				end
				1: begin
					send_idle_pct = 48;
					recv_idle_pct = 12;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int unsigned sub = 0; sub < 3; sub++) begin
				write_window(pick_window(mode * 3 + sub));
				run_streams(RANDOM_ITEMS / SUB_PHASES);
				settle();
			end
		end

		// settle() already waited out the tail; any stray result was flagged.
		if (sb.fail_count == 0 && sb.pending() == 0)
			$display("min_of_window_maxima verification clean");
		else
			$display("min_of_window_maxima verification failed");
		$finish;
	end

endmodule
